>>> hdl/copsa_pkg.sv
// Shared types and constants for the center-out pan slot allocator.
// Used by copsa_cell, copsa_row and center_out_pan_slot_allocator_core.
package copsa_pkg;

  localparam int MAX_VOICES_DEF = 16;
  localparam int RESET_VOICES   = 12;
  localparam int RESET_WIDTH    = 64;
  localparam int WIDTH_MAX      = 100;
  localparam int PAN_W          = 7;
  localparam int POS_W          = 7;
  localparam int CNT_W          = 5;
  localparam int ADDR_W         = 2;
  localparam logic [ADDR_W-1:0] REG_NUM_VOICES = 2'd0;

  typedef enum logic [1:0] {
    OP_TAKE_NEXT    = 2'd0,
    OP_TAKE_CLOSEST = 2'd1,
    OP_RELEASE      = 2'd2,
    OP_SET_WIDTH    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PAN_W-1:0] operand;
  } req_word_t;

  typedef struct packed {
    logic [PAN_W-1:0] pan_value;
    logic             pan_valid;
    logic [CNT_W-1:0] free_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ROW_HOLD,
    ROW_LOAD,
    ROW_REMOVE,
    ROW_INSERT,
    ROW_WRITE
  } row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [POS_W-1:0] pos;
    logic [PAN_W-1:0] data;
  } row_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BC,
    S_BB,
    S_BM,
    S_BD,
    S_BW,
    S_BEND,
    S_FILL,
    S_TAKE,
    S_SCAN,
    S_TCL,
    S_RT,
    S_RS,
    S_RI,
    S_PL,
    S_MS,
    S_MW,
    S_RSP
  } state_t;

endpackage

>>> hdl/copsa_cell.sv
// One list cell: holds a pan value and shifts to or from its neighbors.
// Depends on copsa_pkg.
module copsa_cell import copsa_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  row_ctl_t         ctl,
  input  logic [PAN_W-1:0] load_val,
  input  logic [PAN_W-1:0] left_val,
  input  logic [PAN_W-1:0] right_val,
  output logic [PAN_W-1:0] val
);

  localparam logic [POS_W-1:0] ME = POS_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ROW_HOLD: begin
      end
      ROW_LOAD: begin
        val <= load_val;
      end
      ROW_REMOVE: begin
        // close the gap: everything at or past pos moves one place left
        if (ME >= ctl.pos) val <= right_val;
      end
      ROW_INSERT: begin
        if (ME > ctl.pos) val <= left_val;
        else if (ME == ctl.pos) val <= ctl.data;
      end
      ROW_WRITE: begin
        if (ME == ctl.pos) val <= ctl.data;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/copsa_row.sv
// Row of list cells chained left to right; one shared control word per cycle.
// Depends on copsa_pkg and copsa_cell.
module copsa_row import copsa_pkg::*; #(
  parameter int N = MAX_VOICES_DEF
) (
  input  logic             clk,
  input  row_ctl_t         ctl,
  input  logic [PAN_W-1:0] load_vals [N],
  output logic [PAN_W-1:0] vals [N]
);

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [PAN_W-1:0] left_v;
    logic [PAN_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end

    if (g == N-1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end

    copsa_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_val  (load_vals[g]),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (vals[g])
    );
  end

endmodule

>>> hdl/center_out_pan_slot_allocator_core.sv
// Center-out pan slot allocator: sequencer, position table, free list and pool rows.
// Depends on copsa_pkg, copsa_row and copsa_cell.
//
// Request channel (req_valid/req_stall/req) carries opcode and operand; each
// word gives exactly one response word (rsp_valid/rsp_stall/rsp) with the pan,
// its valid flag and the free-list length after the step. One word is worked
// on at a time; the response sits in an output register, so a stalled
// receiver only holds the sequencer in its final state.
// Steps per word: take next and take closest refill an empty list first;
//   set width rebuilds the table (a multiply-add and a 7-step divide per
//   slot), then refills the list when it was empty, else remaps, which
//   scans the shrinking pool row once for each free entry.
// The APB register num_voices (address 0) clamps to 1..MAX_VOICES; a write
// rebuilds the table and refills the list with req stalled. After reset the
// same rebuild runs for 12 voices (at most MAX_VOICES) at width 64 before
// the first request word is taken.
module center_out_pan_slot_allocator_core import copsa_pkg::*; #(
  parameter int MAX_VOICES = MAX_VOICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_word_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_word_t         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(MAX_VOICES + 1);
  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int NW = $clog2(25600 * MAX_VOICES + 1);
  localparam int CW = 14;
  localparam int RV = (RESET_VOICES > MAX_VOICES) ? MAX_VOICES : RESET_VOICES;
  localparam logic [IW-1:0] ONE = IW'(1);

  state_t state, state_next;

  logic [IW-1:0]    nv;
  logic             cfg_pend;
  logic [PAN_W-1:0] cur_w;
  logic [PAN_W-1:0] tbl [MAX_VOICES];
  logic [IW-1:0]    flen;
  logic [IW-1:0]    plen;
  logic [1:0]       op_r;
  logic [PAN_W-1:0] arg_r;
  logic             item;
  logic             after_w;
  logic [CW-1:0]    coef;
  logic [NW-1:0]    base;
  logic [NW-1:0]    num;
  logic [PAN_W-1:0] q;
  logic [2:0]       s;
  logic [IW-1:0]    k;
  logic [IW-1:0]    i;
  logic [IW-1:0]    j;
  logic [IW-1:0]    best;
  logic [7:0]       bestd;
  logic [IW-1:0]    t;
  logic [PAN_W-1:0] pan;
  logic             pvalid;

  row_ctl_t         fr_ctl, pl_ctl;
  logic [PAN_W-1:0] fr_vals [MAX_VOICES];
  logic [PAN_W-1:0] pl_vals [MAX_VOICES];
  logic [IW-1:0]    fr_addr, pl_addr;
  logic [PAN_W-1:0] fr_rd, pl_rd;

  logic [IW-1:0]    mid, slot_idx;
  logic [IW:0]      half, sum;
  logic [NW-1:0]    den, prod;
  logic [NW+6:0]    dsh;
  logic             ge;
  logic [PAN_W-1:0] da, db, gap;
  logic             closer;
  logic             hit, inpre;
  logic [IW-1:0]    tf;
  logic [IW-1:0]    nv_wr;
  logic [PAN_W-1:0] w_sat;
  logic             cfg_wr, req_acc;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_NUM_VOICES);
  assign prdata = (paddr == REG_NUM_VOICES) ? 32'(nv) : '0;

  always_comb begin
    if (pwdata[4:0] == 5'd0) nv_wr = ONE;
    else if (int'(pwdata[4:0]) > MAX_VOICES) nv_wr = IW'(MAX_VOICES);
    else nv_wr = IW'(pwdata[4:0]);
  end

  assign w_sat = (int'(req.operand) > WIDTH_MAX) ? PAN_W'(WIDTH_MAX) : req.operand;

  // ---------------------------------------------------------------- table math
  // slot index for assigning-order position k: middle, then left/right alternating
  always_comb begin
    mid  = (nv > ONE) ? (nv >> 1) : '0;
    half = '0;
    sum  = '0;
    if (k == '0) begin
      slot_idx = mid;
    end else if (k[0]) begin
      half     = ({1'b0, k} + (IW+1)'(1)) >> 1;
      slot_idx = (half <= {1'b0, mid}) ? IW'({1'b0, mid} - half) : '0;
    end else begin
      half     = {1'b0, k} >> 1;
      sum      = {1'b0, mid} + half;
      slot_idx = (sum >= {1'b0, nv}) ? (nv - ONE) : IW'(sum);
    end
  end

  assign prod = NW'(coef) * NW'({slot_idx, 1'b1});
  assign den  = NW'(nv) * NW'(200);
  assign dsh  = (NW+7)'(den) << s;
  assign ge   = (NW+7)'(num) >= dsh;

  // ---------------------------------------------------------------- rows
  assign fr_rd = fr_vals[fr_addr[AW-1:0]];
  assign pl_rd = pl_vals[pl_addr[AW-1:0]];

  copsa_row #(.N(MAX_VOICES)) u_free (
    .clk       (clk),
    .ctl       (fr_ctl),
    .load_vals (tbl),
    .vals      (fr_vals)
  );

  copsa_row #(.N(MAX_VOICES)) u_pool (
    .clk       (clk),
    .ctl       (pl_ctl),
    .load_vals (tbl),
    .vals      (pl_vals)
  );

  assign da     = (state == S_MS) ? pl_rd : fr_rd;
  assign db     = (state == S_MS) ? fr_rd : arg_r;
  assign gap    = (da > db) ? (da - db) : (db - da);
  assign closer = {1'b0, gap} < bestd;

  // first table position holding the released value
  always_comb begin
    hit = 1'b0;
    tf  = '0;
    for (int kk = MAX_VOICES - 1; kk >= 0; kk--) begin
      if (IW'(kk) < nv && tbl[kk] == arg_r) begin
        hit = 1'b1;
        tf  = IW'(kk);
      end
    end
  end

  // free entry already appears at or before the released value's position
  always_comb begin
    inpre = 1'b0;
    for (int kk = 0; kk < MAX_VOICES; kk++) begin
      if (IW'(kk) <= t && tbl[kk] == fr_rd) inpre = 1'b1;
    end
  end

  assign req_stall = !(state == S_IDLE && !cfg_pend);
  assign req_acc   = req_valid && !req_stall;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_BC;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    fr_ctl     = '{op: ROW_HOLD, pos: '0, data: '0};
    pl_ctl     = '{op: ROW_HOLD, pos: '0, data: '0};
    fr_addr    = j;
    pl_addr    = j;
    unique case (state)
      S_IDLE: begin
        if (cfg_pend) begin
          state_next = S_BC;
        end else if (req_valid) begin
          unique case (opcode_t'(req.opcode))
            OP_TAKE_NEXT:    state_next = (flen == '0) ? S_FILL : S_TAKE;
            OP_TAKE_CLOSEST: begin
              if (flen < IW'(2)) state_next = (flen == '0) ? S_FILL : S_TAKE;
              else state_next = S_SCAN;
            end
            OP_RELEASE:      state_next = S_RT;
            OP_SET_WIDTH:    state_next = S_BC;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_BC:  state_next = S_BB;
      S_BB:  state_next = S_BM;
      S_BM:  state_next = S_BD;
      S_BD:  if (s == 3'd0) state_next = S_BW;
      S_BW:  state_next = (k + ONE == nv) ? S_BEND : S_BM;
      S_BEND: state_next = (!after_w || flen == '0) ? S_FILL : S_PL;
      S_FILL: begin
        fr_ctl.op = ROW_LOAD;
        if (!item) state_next = S_IDLE;
        else if (opcode_t'(op_r) == OP_SET_WIDTH) state_next = S_RSP;
        else state_next = S_TAKE;
      end
      S_TAKE: begin
        fr_addr    = '0;
        fr_ctl.op  = ROW_REMOVE;
        state_next = S_RSP;
      end
      S_SCAN: begin
        fr_addr = j;
        if (j + ONE == flen) state_next = S_TCL;
      end
      S_TCL: begin
        fr_addr    = best;
        fr_ctl.op  = ROW_REMOVE;
        fr_ctl.pos = POS_W'(best);
        state_next = S_RSP;
      end
      S_RT: state_next = (!hit || flen >= nv) ? S_RSP : S_RS;
      S_RS: begin
        fr_addr = i;
        if (i == flen || !inpre) state_next = S_RI;
      end
      S_RI: begin
        fr_ctl     = '{op: ROW_INSERT, pos: POS_W'(i), data: arg_r};
        state_next = S_RSP;
      end
      S_PL: begin
        pl_ctl.op  = ROW_LOAD;
        state_next = S_MS;
      end
      S_MS: begin
        fr_addr = i;
        pl_addr = j;
        if (j + ONE == plen) state_next = S_MW;
      end
      S_MW: begin
        pl_addr    = best;
        fr_ctl     = '{op: ROW_WRITE, pos: POS_W'(i), data: pl_rd};
        pl_ctl     = '{op: ROW_REMOVE, pos: POS_W'(best), data: '0};
        state_next = (i + ONE == flen) ? S_RSP : S_MS;
      end
      S_RSP: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      nv        <= IW'(RV);
      cur_w     <= PAN_W'(RESET_WIDTH);
      cfg_pend  <= 1'b0;
      flen      <= '0;
      item      <= 1'b0;
      after_w   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        nv       <= nv_wr;
        cfg_pend <= 1'b1;
      end else if (state == S_IDLE) begin
        cfg_pend <= 1'b0;
      end

      if (state == S_RSP && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cfg_pend) begin
            item     <= 1'b0;
            after_w  <= 1'b0;
          end else if (req_acc) begin
            item    <= 1'b1;
            op_r    <= req.opcode;
            arg_r   <= req.operand;
            pan     <= '0;
            pvalid  <= 1'b0;
            j       <= '0;
            bestd   <= 8'hFF;
            after_w <= 1'b1;
            if (opcode_t'(req.opcode) == OP_SET_WIDTH) cur_w <= w_sat;
          end
        end
        S_BC: coef <= CW'(cur_w) * CW'(127);
        S_BB: begin
          base <= NW'(nv) * NW'(12800) - NW'(coef) * NW'(nv);
          k    <= '0;
        end
        S_BM: begin
          num <= base + prod;
          s   <= 3'd6;
          q   <= '0;
        end
        S_BD: begin
          // restoring divide, one quotient bit per cycle
          if (ge) begin
            num  <= NW'((NW+7)'(num) - dsh);
            q[s] <= 1'b1;
          end
          s <= s - 3'd1;
        end
        S_BW: begin
          tbl[k[AW-1:0]] <= q;
          k              <= k + ONE;
        end
        S_BEND: begin
        end
        S_FILL: flen <= nv;
        S_TAKE: begin
          pan    <= fr_rd;
          pvalid <= 1'b1;
          flen   <= flen - ONE;
        end
        S_SCAN: begin
          if (closer) begin
            bestd <= {1'b0, gap};
            best  <= j;
          end
          j <= j + ONE;
        end
        S_TCL: begin
          pan    <= fr_rd;
          pvalid <= 1'b1;
          flen   <= flen - ONE;
        end
        S_RT: begin
          t <= tf;
          i <= '0;
        end
        S_RS: if (!(i == flen || !inpre)) i <= i + ONE;
        S_RI: flen <= flen + ONE;
        S_PL: begin
          plen  <= nv;
          i     <= '0;
          j     <= '0;
          bestd <= 8'hFF;
        end
        S_MS: begin
          if (closer) begin
            bestd <= {1'b0, gap};
            best  <= j;
          end
          j <= j + ONE;
        end
        S_MW: begin
          plen  <= plen - ONE;
          i     <= i + ONE;
          j     <= '0;
          bestd <= 8'hFF;
        end
        S_RSP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.pan_value  <= pan;
            rsp.pan_valid  <= pvalid;
            rsp.free_count <= CNT_W'(flen);
            item           <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
